### hdl/zvd_input_shaper_defines.svh
// Assertion macros for the checker file of the input shaper.
`ifndef ZVD_INPUT_SHAPER_DEFINES_SVH
`define ZVD_INPUT_SHAPER_DEFINES_SVH

// Implication into the next cycle, switched off while reset is held.
`define ZVD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Implication into the next cycle that is also checked through reset.
`define ZVD_ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/zvd_pkg.sv
package zvd_pkg;

    localparam int SAMPLE_W    = 24;
    localparam int COEF_W      = 18;
    localparam int SPACING_W   = 9;
    localparam int FRAC_W      = 17;
    localparam int PROD_W      = COEF_W + 1 + SAMPLE_W;
    localparam int ACC_W       = PROD_W + 2;
    localparam int RES_W       = ACC_W - FRAC_W;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 18;
    localparam int CMD_DEPTH   = 4;
    localparam int OUT_DEPTH   = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_SHAPING_ENABLE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TAP_SPACING    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_COEF_NOW       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_COEF_MID       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_COEF_FAR       = 3'd4;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    localparam logic [COEF_W-1:0] COEF_ONE = 18'd131072;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;
    localparam logic signed [ACC_W-1:0]    ROUND_BIAS = 45'sd65536;

    typedef struct packed {
        logic                       op;
        logic signed [SAMPLE_W-1:0] value;
    } t_cmd;

    typedef struct packed {
        logic              enable;
        logic              spacing_nz;
        logic [COEF_W-1:0] coef_now;
        logic [COEF_W-1:0] coef_mid;
        logic [COEF_W-1:0] coef_far;
    } t_cfg;

    typedef struct packed {
        logic clearing;
    } t_back_status;

endpackage

### hdl/zvd_fifo.sv
module zvd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_data,
    output logic                       o_full,
    output logic                       o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_slot [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic             do_push;
    logic             do_pop;

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_data  = r_slot[r_rd];

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr] <= i_data;
        end
    end

endmodule

### hdl/zvd_front.sv
module zvd_front import zvd_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic                       i_req_type,
    input  logic signed [SAMPLE_W-1:0] i_sample_value,
    input  logic                       i_block,
    output logic                       o_full,
    output logic                       o_cmd_valid,
    output t_cmd                       o_cmd,
    input  logic                       i_cmd_take
);

    t_cmd                  new_cmd;
    logic [$bits(t_cmd)-1:0] q_data;
    logic                  q_full;
    logic                  q_empty;

    always_comb begin
        new_cmd.op    = i_req_type ? OP_FLUSH : OP_SAMPLE;
        new_cmd.value = i_sample_value;
    end

    zvd_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push && !o_full),
        .i_data  (new_cmd),
        .i_pop   (i_cmd_take),
        .o_data  (q_data),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_count ()
    );

    assign o_full      = q_full || i_block;
    assign o_cmd_valid = !q_empty;
    assign o_cmd       = q_data;

endmodule

### hdl/zvd_back.sv
module zvd_back import zvd_pkg::*; #(
    parameter int LINE_DEPTH = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  t_cfg                                i_cfg,
    input  logic [$clog2(LINE_DEPTH)-1:0]       i_off1,
    input  logic [$clog2(LINE_DEPTH)-1:0]       i_off2,
    input  logic                                i_cmd_valid,
    input  t_cmd                                i_cmd,
    output logic                                o_cmd_take,
    input  logic [$clog2(OUT_DEPTH+1)-1:0]      i_out_count,
    output logic                                o_out_push,
    output logic signed [SAMPLE_W-1:0]          o_out_data,
    output t_back_status                        o_status
);

    localparam int AW = $clog2(LINE_DEPTH);
    localparam int OW = $clog2(OUT_DEPTH + 1);

    logic [SAMPLE_W-1:0] r_mem [LINE_DEPTH];
    logic [SAMPLE_W-1:0] r_rd1;
    logic [SAMPLE_W-1:0] r_rd2;

    logic [AW-1:0]       r_head;
    logic                r_fill_active;
    logic                r_clearing;
    logic [AW-1:0]       r_fill_idx;
    logic [SAMPLE_W-1:0] r_fill_val;

    logic                       r_s1_valid;
    logic                       r_s1_shape;
    logic                       r_s1_fwd1;
    logic                       r_s1_fwd2;
    logic signed [SAMPLE_W-1:0] r_s1_x;

    logic                       r_s2_valid;
    logic                       r_s2_shape;
    logic signed [SAMPLE_W-1:0] r_s2_x;
    logic signed [PROD_W-1:0]   r_p0;
    logic signed [PROD_W-1:0]   r_p1;
    logic signed [PROD_W-1:0]   r_p2;

    logic                       r_s3_valid;
    logic                       r_s3_shape;
    logic signed [SAMPLE_W-1:0] r_s3_x;
    logic signed [ACC_W-1:0]    r_sum;

    logic                       fill_done;
    logic [OW-1:0]              inflight;
    logic                       room;
    logic                       take;
    logic                       issue_sample;
    logic                       start_fill;
    logic                       mem_we;
    logic [AW-1:0]              mem_waddr;
    logic [SAMPLE_W-1:0]        mem_wdata;
    logic [AW-1:0]              addr1;
    logic [AW-1:0]              addr2;
    logic signed [SAMPLE_W-1:0] tap1;
    logic signed [SAMPLE_W-1:0] tap2;
    logic signed [PROD_W-1:0]   n_p0;
    logic signed [PROD_W-1:0]   n_p1;
    logic signed [PROD_W-1:0]   n_p2;
    logic signed [ACC_W-1:0]    n_sum;
    logic signed [RES_W-1:0]    rounded;
    logic signed [SAMPLE_W-1:0] shaped;

    assign fill_done = r_fill_active && (r_fill_idx == AW'(LINE_DEPTH - 1));
    assign inflight  = OW'(r_s1_valid) + OW'(r_s2_valid) + OW'(r_s3_valid);
    assign room      = (i_out_count + inflight) < OW'(OUT_DEPTH);
    assign take      = i_cmd_valid && !r_fill_active && ((i_cmd.op == OP_FLUSH) || room);
    assign issue_sample = take && (i_cmd.op == OP_SAMPLE);
    assign start_fill   = take && (i_cmd.op == OP_FLUSH);
    assign o_cmd_take   = take;
    assign o_status.clearing = r_clearing;

    assign addr1 = (r_head >= i_off1) ? r_head - i_off1 : r_head + AW'(LINE_DEPTH) - i_off1;
    assign addr2 = (r_head >= i_off2) ? r_head - i_off2 : r_head + AW'(LINE_DEPTH) - i_off2;

    assign mem_we    = r_fill_active || issue_sample;
    assign mem_waddr = r_fill_active ? r_fill_idx : r_head;
    assign mem_wdata = r_fill_active ? r_fill_val : i_cmd.value;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd1 <= r_mem[addr1];
        r_rd2 <= r_mem[addr2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head        <= '0;
            r_fill_active <= 1'b1;
            r_clearing    <= 1'b1;
            r_fill_idx    <= '0;
            r_fill_val    <= '0;
        end else begin
            if (issue_sample) begin
                r_head <= (r_head == AW'(LINE_DEPTH - 1)) ? '0 : r_head + 1'b1;
            end
            if (start_fill) begin
                r_fill_active <= 1'b1;
                r_fill_idx    <= '0;
                r_fill_val    <= i_cmd.value;
            end else if (fill_done) begin
                r_fill_active <= 1'b0;
                r_clearing    <= 1'b0;
            end else if (r_fill_active) begin
                r_fill_idx <= r_fill_idx + 1'b1;
            end
        end
    end

    always_comb begin
        tap1  = r_s1_fwd1 ? r_s1_x : $signed(r_rd1);
        tap2  = r_s1_fwd2 ? r_s1_x : $signed(r_rd2);
        n_p0  = $signed({1'b0, i_cfg.coef_now}) * r_s1_x;
        n_p1  = $signed({1'b0, i_cfg.coef_mid}) * tap1;
        n_p2  = $signed({1'b0, i_cfg.coef_far}) * tap2;
        n_sum = ACC_W'(r_p0) + ACC_W'(r_p1) + ACC_W'(r_p2) + ROUND_BIAS;
    end

    always_comb begin
        rounded = r_sum[ACC_W-1:FRAC_W];
        if (rounded > RES_W'(SAMPLE_MAX)) begin
            shaped = SAMPLE_MAX;
        end else if (rounded < RES_W'(SAMPLE_MIN)) begin
            shaped = SAMPLE_MIN;
        end else begin
            shaped = rounded[SAMPLE_W-1:0];
        end
    end

    assign o_out_push = r_s3_valid;
    assign o_out_data = r_s3_shape ? shaped : r_s3_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            r_s1_valid <= issue_sample;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_x     <= i_cmd.value;
        r_s1_shape <= i_cfg.enable && i_cfg.spacing_nz;
        r_s1_fwd1  <= (i_off1 == '0);
        r_s1_fwd2  <= (i_off2 == '0);
        r_s2_x     <= r_s1_x;
        r_s2_shape <= r_s1_shape;
        r_p0       <= n_p0;
        r_p1       <= n_p1;
        r_p2       <= n_p2;
        r_s3_x     <= r_s2_x;
        r_s3_shape <= r_s2_shape;
        r_sum      <= n_sum;
    end

endmodule

### hdl/zvd_input_shaper.sv
// Three-impulse input shaper for a stream of signed 24-bit samples.
// Items enter through a queue-like port: a transaction is accepted when i_push is high
// and o_full is low. i_req_type low shapes i_sample_value (or passes it on while shaping is
// off), high fills the whole delay line with i_sample_value and yields no result.
// Results leave the same way: o_shaped_value is valid while o_empty is low and the
// transaction completes when i_pop is high.
// Registers are written through i_cfg_valid/o_cfg_ready with i_cfg_index and i_cfg_data;
// the user must do so only while no item is in progress; the block does not enforce this.
// o_cfg_ready is always high. An accepted sample passes the registered stages s1, s2
// and s3 and then the output queue. One sample a cycle is sustained while no fill runs
// and the output queue has room, as the single write port and the two registered read
// ports of the delay line serve one sample per cycle. A fill occupies that write port
// until it has written every address, and later samples wait in the input queue.
// After reset the delay line is cleared, o_full held high until all of it is written.
// When the receiver stalls, up to eight results are held; the input queue then fills and
// o_full rises.
module zvd_input_shaper import zvd_pkg::*; #(
    parameter int LINE_DEPTH = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    output logic                         o_full,
    input  logic                         i_req_type,
    input  logic signed [SAMPLE_W-1:0]   i_sample_value,
    output logic                         o_empty,
    input  logic                         i_pop,
    output logic signed [SAMPLE_W-1:0]   o_shaped_value,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data
);

    localparam int AW = $clog2(LINE_DEPTH);

    t_cfg                r_cfg;
    logic [AW-1:0]       r_off1;
    logic [AW-1:0]       r_off2;
    logic                cfg_we;

    logic                cmd_valid;
    t_cmd                cmd;
    logic                cmd_take;
    t_back_status        back_status;
    logic                out_push;
    logic [SAMPLE_W-1:0] out_data;
    logic [SAMPLE_W-1:0] outq_data;
    logic [$clog2(OUT_DEPTH+1)-1:0] outq_count;

    function automatic logic [SPACING_W:0] tap_reduce(input logic [SPACING_W:0] v);
        logic [SPACING_W:0] t;
        t = v;
        for (int k = 7; k >= 0; k--) begin
            if ((LINE_DEPTH << k) < (1 << (SPACING_W + 1))) begin
                if (t >= (SPACING_W + 1)'(LINE_DEPTH << k)) begin
                    t = t - (SPACING_W + 1)'(LINE_DEPTH << k);
                end
            end
        end
        return t;
    endfunction

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable     <= 1'b0;
            r_cfg.spacing_nz <= 1'b0;
            r_cfg.coef_now   <= COEF_ONE;
            r_cfg.coef_mid   <= '0;
            r_cfg.coef_far   <= '0;
            r_off1           <= '0;
            r_off2           <= '0;
        end else if (cfg_we) begin
            case (i_cfg_index)
                CFG_SHAPING_ENABLE: begin
                    r_cfg.enable <= i_cfg_data[0];
                end
                CFG_TAP_SPACING: begin
                    r_cfg.spacing_nz <= (i_cfg_data[SPACING_W-1:0] != '0);
                    r_off1 <= AW'(tap_reduce({1'b0, i_cfg_data[SPACING_W-1:0]}));
                    r_off2 <= AW'(tap_reduce({i_cfg_data[SPACING_W-1:0], 1'b0}));
                end
                CFG_COEF_NOW: begin
                    r_cfg.coef_now <= i_cfg_data[COEF_W-1:0];
                end
                CFG_COEF_MID: begin
                    r_cfg.coef_mid <= i_cfg_data[COEF_W-1:0];
                end
                CFG_COEF_FAR: begin
                    r_cfg.coef_far <= i_cfg_data[COEF_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    zvd_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (i_push),
        .i_req_type     (i_req_type),
        .i_sample_value (i_sample_value),
        .i_block        (back_status.clearing),
        .o_full         (o_full),
        .o_cmd_valid    (cmd_valid),
        .o_cmd          (cmd),
        .i_cmd_take     (cmd_take)
    );

    zvd_back #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_off1      (r_off1),
        .i_off2      (r_off2),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .i_out_count (outq_count),
        .o_out_push  (out_push),
        .o_out_data  (out_data),
        .o_status    (back_status)
    );

    zvd_fifo #(
        .WIDTH (SAMPLE_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (out_data),
        .i_pop   (i_pop),
        .o_data  (outq_data),
        .o_full  (),
        .o_empty (o_empty),
        .o_count (outq_count)
    );

    assign o_shaped_value = $signed(outq_data);

endmodule

### hdl/zvd_checker.sv
`include "zvd_input_shaper_defines.svh"

module zvd_checker import zvd_pkg::*; (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_push,
    input logic                       o_full,
    input logic                       o_empty,
    input logic                       i_pop,
    input logic signed [SAMPLE_W-1:0] o_shaped_value
);

    // Reset empties the result side and blocks the input side for the clearing pass.
    `ZVD_ASSERT_ALWAYS(a_reset_state, i_clk, !i_rst_n, o_empty && o_full, "bad state after reset")

    // The clearing pass still holds o_full high in the cycle after the one in which reset is released.
    `ZVD_ASSERT_ALWAYS(a_clear_holds, i_clk, !i_rst_n ##1 i_rst_n, o_full, "clearing ended early")

    // A waiting result stays put until a pop transaction takes it.
    `ZVD_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, !o_empty && !i_pop, !o_empty && $stable(o_shaped_value), "result changed while stalled")

    // Just after reset, a block with nothing pending hands out no result without a push transaction.
    `ZVD_ASSERT_NEXT(a_no_spurious, i_clk, i_rst_n, o_full && o_empty && !i_push && $past(!i_rst_n), o_empty, "result without a transaction")

endmodule

bind zvd_input_shaper zvd_checker u_checker (.*);
